// ===== rtl/wft_pkg.sv =====
`default_nettype none

package wft_pkg;

  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Horizontal tab, line feed, vertical tab, form feed, carriage return, and space
  function automatic logic is_space(input logic [7:0] b);
    is_space = (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/word_frequency_table.sv =====
// A text byte that does not close a word is taken in idle and gives no result.
// A byte that closes a word scans the stored entries at one per cycle through the
// single read port of the entry memory, then moves to the emit state on a hit or
// on a miss with room to insert; a read reaches it via the read state. The next
// input is taken in the cycle after the result loads; a finished result waits in the
// output register. Reset (rst, sync) empties the table; limit = min(ENTRIES, 256).
`default_nettype none

module word_frequency_table #(
  parameter int ENTRIES      = 256,
  parameter int MAX_WORD_LEN = 49
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [$clog2(ENTRIES):0]            cfg_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                command,
  input  wire [7:0]                          text_byte,
  input  wire                                end_of_text,
  input  wire [$clog2(ENTRIES)-1:0]          read_index,
  input  wire [$clog2(MAX_WORD_LEN+1)-1:0]   char_position,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [$clog2(ENTRIES)-1:0]         entry_index,
  output logic [wft_pkg::COUNT_W-1:0]        frequency,
  output logic                               inserted,
  output logic                               table_full,
  output logic [$clog2(ENTRIES):0]           unique_count,
  output logic [$clog2(MAX_WORD_LEN+1)-1:0]  word_length,
  output logic [7:0]                         word_byte,
  output logic                               valid_entry
);
  import wft_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int KEY_W = MAX_WORD_LEN * 8;
  localparam int ROW_W = LEN_W + COUNT_W + KEY_W;
  localparam int LIMIT_RST = (ENTRIES < 256) ? ENTRIES : 256;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  // Row layout: {length, count, key bytes}
  logic [ROW_W-1:0] mem [ENTRIES];
  logic [ROW_W-1:0] rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;

  logic [1:0]       state;
  logic [LEN_W-1:0] cur_len;
  logic [KEY_W-1:0] cur_word;
  logic [IDX_W:0]   entry_count;
  logic             stopped;
  logic [IDX_W:0]   table_limit;
  logic [IDX_W:0]   issue_idx;
  logic             cmp_pending;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] req_idx;
  logic [LEN_W-1:0] req_pos;

  logic [IDX_W-1:0]   p_idx;
  logic [COUNT_W-1:0] p_freq;
  logic               p_ins;
  logic [LEN_W-1:0]   p_len;
  logic [7:0]         p_byte;
  logic               p_valid;

  logic [LEN_W-1:0]   rd_len;
  logic [COUNT_W-1:0] rd_cnt;
  logic [KEY_W-1:0]   rd_key;
  logic               key_eq;
  logic               hit;
  logic               more;
  logic               miss;
  logic [COUNT_W-1:0] cnt_inc;
  logic [IDX_W:0]     eff_limit;
  logic [IDX_W:0]     count_after;
  logic               accept;
  logic               is_ws;
  logic [LEN_W-1:0]   len_ins;
  logic               close_word;
  logic               out_free;

  assign rd_len = rd_data[ROW_W-1 -: LEN_W];
  assign rd_cnt = rd_data[KEY_W +: COUNT_W];
  assign rd_key = rd_data[KEY_W-1:0];

  always_comb begin
    key_eq = (rd_len == cur_len);
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      if (LEN_W'(k) < cur_len && rd_key[k*8 +: 8] != cur_word[k*8 +: 8]) begin
        key_eq = 1'b0;
      end
    end
  end

  assign hit     = (state == S_SCAN) && cmp_pending && key_eq;
  assign more    = issue_idx < entry_count;
  assign miss    = (state == S_SCAN) && !more && !hit;
  assign cnt_inc = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

  always_comb begin
    if (table_limit == '0) begin
      eff_limit = (IDX_W+1)'(1);
    end else if (table_limit > (IDX_W+1)'(ENTRIES)) begin
      eff_limit = (IDX_W+1)'(ENTRIES);
    end else begin
      eff_limit = table_limit;
    end
  end

  assign count_after = hit ? entry_count : entry_count + 1'b1;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_ws      = is_space(text_byte);
  assign len_ins    = cur_len + 1'b1;
  assign close_word = is_ws ? (cur_len != '0)
                            : (len_ins >= LEN_W'(MAX_WORD_LEN) || end_of_text);
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = cmp_idx;
    wr_data = {rd_len, cnt_inc, rd_key};
    if (accept && command == CMD_READ) begin
      rd_en   = 1'b1;
      rd_addr = read_index;
    end else if (state == S_SCAN) begin
      // Stop issuing once a compare hits so the hit row stays in rd_data
      rd_en = more && !hit;
      if (hit) begin
        wr_en = 1'b1;
      end else if (miss && entry_count < (IDX_W+1)'(ENTRIES)) begin
        wr_en   = 1'b1;
        wr_addr = entry_count[IDX_W-1:0];
        wr_data = {cur_len, COUNT_W'(1), cur_word};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_len     <= '0;
      entry_count <= '0;
      stopped     <= 1'b0;
      table_limit <= (IDX_W+1)'(LIMIT_RST);
      issue_idx   <= '0;
      cmp_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_limit <= cfg_data;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_READ) begin
              req_idx <= read_index;
              req_pos <= char_position;
              state   <= S_READ;
            end else if (!stopped) begin
              if (!is_ws) begin
                cur_word[cur_len*8 +: 8] <= text_byte;
                cur_len                  <= len_ins;
              end
              if (close_word) begin
                issue_idx   <= '0;
                cmp_pending <= 1'b0;
                state       <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            p_idx   <= cmp_idx;
            p_freq  <= cnt_inc;
            p_ins   <= 1'b0;
            p_len   <= rd_len;
            p_byte  <= '0;
            p_valid <= 1'b1;
            cur_len <= '0;
            if (count_after >= eff_limit) begin
              stopped <= 1'b1;
            end
            state <= S_EMIT;
          end else if (miss) begin
            cur_len <= '0;
            if (entry_count < (IDX_W+1)'(ENTRIES)) begin
              p_idx       <= entry_count[IDX_W-1:0];
              p_freq      <= COUNT_W'(1);
              p_ins       <= 1'b1;
              p_len       <= cur_len;
              p_byte      <= '0;
              p_valid     <= 1'b1;
              entry_count <= count_after;
              if (count_after >= eff_limit) begin
                stopped <= 1'b1;
              end
              state <= S_EMIT;
            end else begin
              // Table full with no match: drop the word and stop
              stopped <= 1'b1;
              state   <= S_IDLE;
            end
          end else begin
            issue_idx   <= issue_idx + 1'b1;
            cmp_pending <= rd_en;
            cmp_idx     <= issue_idx[IDX_W-1:0];
          end
        end
        S_READ: begin
          p_idx <= req_idx;
          p_ins <= 1'b0;
          if ({1'b0, req_idx} < entry_count) begin
            p_freq  <= rd_cnt;
            p_len   <= rd_len;
            p_byte  <= (req_pos < rd_len) ? rd_key[req_pos*8 +: 8] : 8'd0;
            p_valid <= 1'b1;
          end else begin
            p_freq  <= '0;
            p_len   <= '0;
            p_byte  <= '0;
            p_valid <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register; loads only when the previous transaction has left
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      entry_index  <= p_idx;
      frequency    <= p_freq;
      inserted     <= p_ins;
      table_full   <= stopped;
      unique_count <= entry_count;
      word_length  <= p_len;
      word_byte    <= p_byte;
      valid_entry  <= p_valid;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= (IDX_W+1)'(ENTRIES))
    else $error("entry count beyond table size");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  a_word_bound: assert property (@(posedge clk) disable iff (rst)
    cur_len <= LEN_W'(MAX_WORD_LEN))
    else $error("open word longer than maximum");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_en)
    else $error("entry memory read and written in one cycle");

  a_insert_tail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && inserted) |-> unique_count == {1'b0, entry_index} + 1'b1)
    else $error("inserted entry is not the last one");

endmodule

`default_nettype wire
